[hw/rtl/kpd_pkg.sv]
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared types and constants for the keypad scanner, debounce and
// axis read trigger.
// ----------------------------------------------------------------------------
package kpd_pkg;

   // matrix geometry
   localparam int unsigned NUM_ROWS = 4;
   localparam int unsigned NUM_COLS = 4;
   localparam int unsigned NUM_KEYS = NUM_ROWS * NUM_COLS;

   // configuration register indexes
   localparam logic [1:0] CSR_PRESS_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_ADDR_X          = 2'd1;
   localparam logic [1:0] CSR_ADDR_Y          = 2'd2;
   localparam logic [1:0] CSR_ADDR_Z          = 2'd3;

   // configuration reset values
   localparam logic [7:0] RST_PRESS_THRESHOLD = 8'd2;
   localparam logic [7:0] RST_ADDR_X          = 8'h29;
   localparam logic [7:0] RST_ADDR_Y          = 8'h2B;
   localparam logic [7:0] RST_ADDR_Z          = 8'h2D;

   // axis codes
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // trigger keys, one per axis
   localparam int unsigned KEY_X = 15;
   localparam int unsigned KEY_Y = 11;
   localparam int unsigned KEY_Z = 7;

   // configuration register set
   typedef struct packed {
      logic [7:0] press_threshold;
      logic [7:0] addr_x;
      logic [7:0] addr_y;
      logic [7:0] addr_z;
   } kpd_cfg_type;

endpackage

[hw/rtl/keypad_scan_debounce_trigger_core.sv]
// ----------------------------------------------------------------------------
// keypad_scan_debounce_trigger_core
// 4x4 keypad scanner: four row lanes count held presses of the driven
// column, a merge stage raises one axis read per new press of the axis keys.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    row_levels
//   rsp      out        rsp_valid/rsp_ready    column_drive, debounced_keys,
//                                              read_request, axis,
//                                              register_address
//   csr      in         csr_wr_en              csr_index, csr_wdata
//
// One item per cycle while rsp is not stalled; the result appears in the cycle
// after the transfer, from the output register of the merge stage.
// A new item is taken whenever the output register is empty or drains in
// the same cycle, so a stall on rsp holds req for as long.
// Synchronous reset clears all counters, the column index and fired marks
// at once and loads the register reset values.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_trigger_core #(
   parameter int unsigned COUNT_WIDTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_row_levels,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_column_drive,
   output logic [15:0] rsp_debounced_keys,
   output logic        rsp_read_request,
   output logic [1:0]  rsp_axis,
   output logic [7:0]  rsp_register_address,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   kpd_pkg::kpd_cfg_type cfg_ff;
   logic [1:0]  column_ff, column_in;
   logic        accept;
   logic [3:0]  lane_pressed [kpd_pkg::NUM_ROWS];
   logic [15:0] key_pressed;

   assign req_ready = !rsp_valid || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign column_in = column_ff + 2'd1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_threshold <= kpd_pkg::RST_PRESS_THRESHOLD;
         cfg_ff.addr_x          <= kpd_pkg::RST_ADDR_X;
         cfg_ff.addr_y          <= kpd_pkg::RST_ADDR_Y;
         cfg_ff.addr_z          <= kpd_pkg::RST_ADDR_Z;
      end else if (csr_wr_en) begin
         case (csr_index)
            kpd_pkg::CSR_PRESS_THRESHOLD: cfg_ff.press_threshold <= csr_wdata;
            kpd_pkg::CSR_ADDR_X:          cfg_ff.addr_x          <= csr_wdata;
            kpd_pkg::CSR_ADDR_Y:          cfg_ff.addr_y          <= csr_wdata;
            kpd_pkg::CSR_ADDR_Z:          cfg_ff.addr_z          <= csr_wdata;
            default: ;
         endcase
      end
   end

   // scan column
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= 2'd0;
      end else if (accept) begin
         column_ff <= column_in;
      end
   end

   // row lanes
   for (genvar r = 0; r < kpd_pkg::NUM_ROWS; r++) begin : g_lane
      kpd_lane #(
         .COUNT_WIDTH(COUNT_WIDTH)
      ) u_lane (
         .clock           (clock),
         .reset           (reset),
         .update          (accept),
         .column          (column_ff),
         .row_level       (req_row_levels[r]),
         .press_threshold (cfg_ff.press_threshold),
         .key_pressed     (lane_pressed[r])
      );
   end

   // key k = 4 * column + row
   always_comb begin
      for (int c = 0; c < kpd_pkg::NUM_COLS; c++) begin
         for (int r = 0; r < kpd_pkg::NUM_ROWS; r++) begin
            key_pressed[c*kpd_pkg::NUM_ROWS + r] = lane_pressed[r][c];
         end
      end
   end

   // merge and result stage
   kpd_merge u_merge (
      .clock                (clock),
      .reset                (reset),
      .accept               (accept),
      .rsp_ready            (rsp_ready),
      .column_next          (column_in),
      .key_pressed          (key_pressed),
      .cfg                  (cfg_ff),
      .rsp_valid            (rsp_valid),
      .rsp_column_drive     (rsp_column_drive),
      .rsp_debounced_keys   (rsp_debounced_keys),
      .rsp_read_request     (rsp_read_request),
      .rsp_axis             (rsp_axis),
      .rsp_register_address (rsp_register_address)
   );

endmodule

[hw/rtl/kpd_lane.sv]
// ----------------------------------------------------------------------------
// kpd_lane
// One row lane: keeps the held-press counters of the four keys on its row,
// updates the one in the driven column and flags keys at threshold.
// ----------------------------------------------------------------------------
module kpd_lane #(
   parameter int unsigned COUNT_WIDTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       update,
   input  logic [1:0] column,
   input  logic       row_level,
   input  logic [7:0] press_threshold,
   output logic [3:0] key_pressed
);

   localparam int unsigned CMP_W = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   logic [COUNT_WIDTH-1:0] count_ff [kpd_pkg::NUM_COLS];
   logic [COUNT_WIDTH-1:0] count_in [kpd_pkg::NUM_COLS];

   // next counts: only the driven column moves, release clears, press saturates
   always_comb begin
      for (int c = 0; c < kpd_pkg::NUM_COLS; c++) begin
         count_in[c] = count_ff[c];
         if (update && (column == 2'(c))) begin
            if (row_level) begin
               count_in[c] = '0;
            end else if (count_ff[c] != COUNT_MAX) begin
               count_in[c] = count_ff[c] + 1'b1;
            end
         end
      end
   end

   // threshold compare on the updated counts
   always_comb begin
      for (int c = 0; c < kpd_pkg::NUM_COLS; c++) begin
         key_pressed[c] = CMP_W'(count_in[c]) >= CMP_W'(press_threshold);
      end
   end

   // counter storage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < kpd_pkg::NUM_COLS; c++) begin
            count_ff[c] <= '0;
         end
      end else begin
         for (int c = 0; c < kpd_pkg::NUM_COLS; c++) begin
            count_ff[c] <= count_in[c];
         end
      end
   end

endmodule

[hw/rtl/kpd_merge.sv]
// ----------------------------------------------------------------------------
// kpd_merge
// Combines the lane flags: priority trigger over the axis keys, fired
// marks, and the registered result stage of the response channel.
// ----------------------------------------------------------------------------
module kpd_merge (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 rsp_ready,
   input  logic [1:0]           column_next,
   input  logic [15:0]          key_pressed,
   input  kpd_pkg::kpd_cfg_type cfg,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_column_drive,
   output logic [15:0]          rsp_debounced_keys,
   output logic                 rsp_read_request,
   output logic [1:0]           rsp_axis,
   output logic [7:0]           rsp_register_address
);

   logic [2:0] fired_ff, fired_in;
   logic       valid_ff, valid_in;
   logic       request;
   logic [1:0] axis;
   logic [7:0] address;

   logic [1:0]  column_ff;
   logic [15:0] keys_ff;
   logic        request_ff;
   logic [1:0]  axis_ff;
   logic [7:0]  address_ff;

   // priority trigger: a qualifying key blocks the ones below it
   always_comb begin
      fired_in = fired_ff;
      request  = 1'b0;
      axis     = 2'd0;
      address  = 8'd0;
      if (key_pressed[kpd_pkg::KEY_X]) begin
         if (!fired_ff[0]) begin
            request     = 1'b1;
            axis        = kpd_pkg::AXIS_X;
            address     = cfg.addr_x;
            fired_in[0] = 1'b1;
         end
      end else if (key_pressed[kpd_pkg::KEY_Y]) begin
         if (!fired_ff[1]) begin
            request     = 1'b1;
            axis        = kpd_pkg::AXIS_Y;
            address     = cfg.addr_y;
            fired_in[1] = 1'b1;
         end
      end else if (key_pressed[kpd_pkg::KEY_Z]) begin
         if (!fired_ff[2]) begin
            request     = 1'b1;
            axis        = kpd_pkg::AXIS_Z;
            address     = cfg.addr_z;
            fired_in[2] = 1'b1;
         end
      end else begin
         fired_in = 3'b000;
      end
   end

   // result valid: set on a new item, cleared when the transfer completes
   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fired_ff <= 3'b000;
         valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            fired_ff <= fired_in;
         end
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         column_ff  <= column_next;
         keys_ff    <= key_pressed;
         request_ff <= request;
         axis_ff    <= axis;
         address_ff <= address;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_column_drive     = column_ff;
   assign rsp_debounced_keys   = keys_ff;
   assign rsp_read_request     = request_ff;
   assign rsp_axis             = axis_ff;
   assign rsp_register_address = address_ff;

endmodule

[test/keypad_scan_debounce_trigger_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keypad_scan_debounce_trigger_core_tb
// Self-checking bench for the 4x4 keypad scanner. Row samples go in over
// req, every scan tick is predicted in the bench (held-press counts,
// column, debounced map, axis read trigger) and each rsp transfer is
// compared with the oldest predicted tick. Threshold and axis addresses
// are changed between phases while the scanner is idle.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_trigger_core_tb;

   localparam int unsigned COUNT_WIDTH = 8;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // one scan tick as seen on rsp
   typedef struct packed {
      logic [1:0]  column_drive;
      logic [15:0] debounced_keys;
      logic        read_request;
      logic [1:0]  axis;
      logic [7:0]  register_address;
   } scan_result_type;

   // tracks scanner state and the ticks still owed on rsp
   class keypad_scoreboard;
      kpd_pkg::kpd_cfg_type   cfg;
      logic [1:0]             column;
      logic [COUNT_WIDTH-1:0] held_count [kpd_pkg::NUM_KEYS];
      logic [2:0]             fired;
      scan_result_type        pending_scans [$];
      int                     errors;
      int unsigned            trigger_key [3]  = '{kpd_pkg::KEY_X, kpd_pkg::KEY_Y,
                                                   kpd_pkg::KEY_Z};
      logic [1:0]             trigger_axis [3] = '{kpd_pkg::AXIS_X, kpd_pkg::AXIS_Y,
                                                   kpd_pkg::AXIS_Z};

      function new();
         cfg.press_threshold = kpd_pkg::RST_PRESS_THRESHOLD;
         cfg.addr_x = kpd_pkg::RST_ADDR_X;
         cfg.addr_y = kpd_pkg::RST_ADDR_Y;
         cfg.addr_z = kpd_pkg::RST_ADDR_Z;
         column = '0;
         foreach (held_count[k]) held_count[k] = '0;
         fired = '0;
         errors = 0;
      endfunction

      function void write_register(logic [1:0] index, logic [7:0] value);
         case (index)
            kpd_pkg::CSR_PRESS_THRESHOLD: cfg.press_threshold = value;
            kpd_pkg::CSR_ADDR_X:          cfg.addr_x = value;
            kpd_pkg::CSR_ADDR_Y:          cfg.addr_y = value;
            kpd_pkg::CSR_ADDR_Z:          cfg.addr_z = value;
            default: ;
         endcase
      endfunction

      // one scan tick for an accepted row sample
      function void note_rows(logic [3:0] rows);
         scan_result_type next_scan;
         int unsigned     k;
         logic            matched;
         next_scan = '0;
         // count held presses of the driven column
         for (int r = 0; r < kpd_pkg::NUM_ROWS; r++) begin
            k = column * kpd_pkg::NUM_ROWS + r;
            if (rows[r])
               held_count[k] = '0;
            else if (held_count[k] != COUNT_MAX)
               held_count[k] = held_count[k] + 1'b1;
         end
         column = column + 2'd1;
         next_scan.column_drive = column;
         for (int j = 0; j < kpd_pkg::NUM_KEYS; j++)
            next_scan.debounced_keys[j] = (held_count[j] >= cfg.press_threshold);
         // priority check of the axis keys, first qualifying key decides
         matched = 1'b0;
         for (int i = 0; i < 3 && !matched; i++) begin
            if (held_count[trigger_key[i]] >= cfg.press_threshold) begin
               matched = 1'b1;
               if (!fired[i]) begin
                  next_scan.read_request = 1'b1;
                  next_scan.axis = trigger_axis[i];
                  case (trigger_axis[i])
                     kpd_pkg::AXIS_X: next_scan.register_address = cfg.addr_x;
                     kpd_pkg::AXIS_Y: next_scan.register_address = cfg.addr_y;
                     default:         next_scan.register_address = cfg.addr_z;
                  endcase
                  fired[i] = 1'b1;
               end
            end
         end
         if (!matched) fired = '0;
         pending_scans.push_back(next_scan);
      endfunction

      function void check_result(scan_result_type got);
         scan_result_type want;
         if (pending_scans.size() == 0) begin
            errors++;
            $display("%0t: unexpected result col=%0d keys=%h req=%b axis=%0d addr=%h",
                     $time, got.column_drive, got.debounced_keys, got.read_request,
                     got.axis, got.register_address);
            return;
         end
         want = pending_scans.pop_front();
         if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected col=%0d keys=%h req=%b axis=%0d addr=%h",
                     $time, want.column_drive, want.debounced_keys, want.read_request,
                     want.axis, want.register_address);
            $display("%0t:          actual   col=%0d keys=%h req=%b axis=%0d addr=%h",
                     $time, got.column_drive, got.debounced_keys, got.read_request,
                     got.axis, got.register_address);
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   logic [3:0]   req_row_levels;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   logic [1:0]   rsp_column_drive;
   logic [15:0]  rsp_debounced_keys;
   logic         rsp_read_request;
   logic [1:0]   rsp_axis;
   logic [7:0]   rsp_register_address;
   logic         csr_wr_en;
   logic [1:0]   csr_index;
   logic [7:0]   csr_wdata;

   scan_result_type  observed;
   keypad_scoreboard sb;
   int unsigned      idle_pct;
   int unsigned      stall_pct;
   int unsigned      scan_col;
   int unsigned      cycle_count = 0;

   keypad_scan_debounce_trigger_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_row_levels       (req_row_levels),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_column_drive     (rsp_column_drive),
      .rsp_debounced_keys   (rsp_debounced_keys),
      .rsp_read_request     (rsp_read_request),
      .rsp_axis             (rsp_axis),
      .rsp_register_address (rsp_register_address),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   assign observed = {rsp_column_drive, rsp_debounced_keys, rsp_read_request,
                      rsp_axis, rsp_register_address};

   // clock
   always #5 clock = ~clock;

   // watch both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_rows(req_row_levels);
         if (rsp_valid && rsp_ready) sb.check_result(observed);
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // run time limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // one row sample transfer, called and returning at a falling edge
   task automatic send_rows(input logic [3:0] rows);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_row_levels <= rows;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      scan_col = (scan_col + 1) % kpd_pkg::NUM_COLS;
   endtask

   task automatic put_csr(input logic [1:0] index, input logic [7:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      sb.write_register(index, value);
      @(negedge clock);
   endtask

   task automatic write_settings(input logic [7:0] thr, input logic [7:0] ax,
                                 input logic [7:0] ay, input logic [7:0] az);
      put_csr(kpd_pkg::CSR_PRESS_THRESHOLD, thr);
      put_csr(kpd_pkg::CSR_ADDR_X, ax);
      put_csr(kpd_pkg::CSR_ADDR_Y, ay);
      put_csr(kpd_pkg::CSR_ADDR_Z, az);
      csr_wr_en <= 1'b0;
   endtask

   // stop sending and let every owed tick come out
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending_scans.size() != 0);
   endtask

   // held key patterns kept for a few full scans, with glitches and noise
   task automatic run_phase(input int unsigned n_items);
      logic [15:0] held;
      logic [3:0]  rows;
      int unsigned scans;
      int unsigned sent;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(4) == 0) begin
            held = '0;
         end else begin
            held = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom & $urandom);
            if ($urandom_range(2) == 0) held[kpd_pkg::KEY_X] = 1'b1;
            if ($urandom_range(2) == 0) held[kpd_pkg::KEY_Y] = 1'b1;
            if ($urandom_range(2) == 0) held[kpd_pkg::KEY_Z] = 1'b1;
         end
         scans = $urandom_range(6, 1);
         for (int s = 0; s < scans * kpd_pkg::NUM_COLS && sent < n_items; s++) begin
            if ($urandom_range(99) < 12) begin
               rows = 4'($urandom);
            end else begin
               rows = ~held[scan_col * kpd_pkg::NUM_ROWS +: kpd_pkg::NUM_ROWS];
               if ($urandom_range(99) < 5) rows = rows ^ (4'b0001 << $urandom_range(3));
            end
            send_rows(rows);
            sent++;
         end
      end
   endtask

   // stimulus
   initial begin
      logic [7:0] thr;
      logic [7:0] ax, ay, az;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_row_levels = '0;
      csr_wr_en = 1'b0;
      csr_index = kpd_pkg::CSR_PRESS_THRESHOLD;
      csr_wdata = '0;
      idle_pct = 0;
      stall_pct = 0;
      scan_col = 0;
      sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all released, then all pressed: Z, Y and X fire in turn
      repeat (4) send_rows(4'hF);
      repeat (8) send_rows(4'h0);
      // release key 15: key 11 qualifies but has fired, so it blocks
      repeat (4) send_rows(scan_col == 3 ? 4'h8 : 4'h0);
      // release key 11 as well: key 7 has fired too
      repeat (4) send_rows(scan_col >= 2 ? 4'h8 : 4'h0);
      // all released clears the fired marks
      repeat (4) send_rows(4'hF);

      // threshold zero: every key debounced, key 15 always qualifies
      wait_idle();
      write_settings(8'd0, 8'h00, 8'hFF, 8'hA5);
      repeat (2) send_rows(4'hF);

      // random phases over idle modes and settings
      for (int mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 53; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 53; end
            default: begin idle_pct = 34; stall_pct = 34; end
         endcase
         for (int sub = 0; sub < 3; sub++) begin
            thr = (sub == 0) ? 8'd1 : 8'($urandom_range(6, 0));
            if (mode == 1 && sub == 0) begin
               ax = 8'h00; ay = 8'h00; az = 8'h00;
            end else if (mode == 2 && sub == 0) begin
               ax = 8'hFF; ay = 8'hFF; az = 8'hFF;
            end else begin
               ax = 8'($urandom); ay = 8'($urandom); az = 8'($urandom);
            end
            wait_idle();
            write_settings(thr, ax, ay, az);
            run_phase(92);
         end
      end

      // threshold at the counter maximum: short holds of row 3 never qualify
      wait_idle();
      idle_pct = 0;
      stall_pct = 34;
      write_settings(8'hFF, 8'($urandom), 8'($urandom), 8'($urandom));
      repeat (24) send_rows({1'b0, 3'($urandom)});
      repeat (4) send_rows(4'hF);

      // drain and let any stray result show up
      wait_idle();
      repeat (4) @(negedge clock);
      if (sb.pending_scans.size() != 0) begin
         sb.errors++;
         $display("%0t: %0d expected results never arrived", $time,
                  sb.pending_scans.size());
      end
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
